// ===== design/kf_pkg.sv =====
// shared types and constants for the position/velocity kalman filter
package kf_pkg;

  localparam int unsigned StW = 48;

  typedef logic signed [StW-1:0] st_t;

  localparam st_t StMax = {1'b0, {(StW-1){1'b1}}};
  localparam st_t StMin = {1'b1, {(StW-1){1'b0}}};

  typedef enum logic [1:0] {
    CFG_MEAS_NOISE = 2'd0,
    CFG_INIT_UNC   = 2'd1,
    CFG_DRIVE_POS  = 2'd2,
    CFG_DRIVE_VEL  = 2'd3
  } cfg_idx_e;

  // saturate a wider signed value into the state range
  function automatic st_t sat48(input logic signed [StW+1:0] v);
    logic signed [StW+1:0] hi;
    logic signed [StW+1:0] lo;
    hi = {{2{StMax[StW-1]}}, StMax};
    lo = {{2{StMin[StW-1]}}, StMin};
    if (v > hi) sat48 = StMax;
    else if (v < lo) sat48 = StMin;
    else sat48 = v[StW-1:0];
  endfunction

  // apply sign to a magnitude and saturate
  function automatic st_t sign_sat(input logic [StW:0] m, input logic neg,
                                   input logic ovf);
    if (neg) begin
      if (ovf || m >= {1'b0, 1'b1, {(StW-1){1'b0}}}) sign_sat = StMin;
      else sign_sat = st_t'(-$signed({1'b0, m[StW-1:0]}));
    end else begin
      if (ovf || m > {2'b00, {(StW-1){1'b1}}}) sign_sat = StMax;
      else sign_sat = m[StW-1:0];
    end
  endfunction

  // saturate a state value to a 32-bit signed output
  function automatic logic [31:0] out32(input st_t v);
    if (v > st_t'(64'sh7FFFFFFF)) out32 = 32'h7FFFFFFF;
    else if (v < -st_t'(64'sh80000000)) out32 = 32'h80000000;
    else out32 = v[31:0];
  endfunction

endpackage

// ===== design/kalman_filter_pos_vel.sv =====
// two-state kalman filter top level with a shared mul/div sequencer
// Most of the work for a sample is two restoring divisions of 48+FRAC_BITS
// steps each, run one bit per cycle on a shared subtractor, each followed by
// a gain write. The six products run one at a time on a single 24x24-bit
// multiplier, each with operand load, four partial products and write-back.
// When the innovation variance is zero the divisions are skipped. The block
// accepts one sample at a time, and s_axis_tready is low from acceptance
// until the result is taken, so a stalled result holds off the next sample.
// Result tdata holds pos_out in bits 31:0 and vel_out in bits 63:32.
// All arithmetic is signed fixed point with FRAC_BITS fraction bits held in
// 48-bit saturating registers; writing init_uncertainty restarts the filter.
module kalman_filter_pos_vel #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_out, vel_out
  output logic [63:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned W    = kf_pkg::StW;
  localparam int unsigned DivN = W + FRAC_BITS;
  localparam int unsigned DcW  = $clog2(DivN + 1);
  localparam int unsigned NiW  = $clog2(W);
  localparam logic [W:0]  LimQ = {1'b0, 1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV0, S_DIV1, S_MUL, S_MULACC, S_PRED, S_OUT
  } state_e;

  state_e state_q;
  logic [31:0] meas_noise_q, init_unc_q;
  logic signed [31:0] drive_pos_q, drive_vel_q;
  kf_pkg::st_t pos_q, vel_q, pp_q, pv_q, vp_q, vv_q;
  kf_pkg::st_t y_q, s_q, k0_q, k1_q;
  kf_pkg::st_t x0_q, x1_q, p00_q, p01_q, p10_q, p11_q;
  logic        out_vld_q;

  // divider
  logic [DcW-1:0] dcnt_q;
  logic [W:0]     rem_q, md_q;
  logic [W:0]     quo_q;
  logic [W-1:0]   mn_q;
  logic           dovf_q, dneg_q;

  // multiplier: four partial products of 24x24
  logic [2:0]     mi_q;         // product index 0..5
  logic [1:0]     pp_idx_q;     // partial product index
  logic [W-1:0]   ma_q, mb_q;
  logic           mneg_q;
  logic [2*W-1:0] acc_q;

  logic [23:0] mul_a, mul_b;
  logic [47:0] mul_p;
  assign mul_a = pp_idx_q[0] ? ma_q[47:24] : ma_q[23:0];
  assign mul_b = pp_idx_q[1] ? mb_q[47:24] : mb_q[23:0];
  assign mul_p = mul_a * mul_b;

  function automatic logic [W-1:0] magn(input kf_pkg::st_t v);
    magn = v[W-1] ? W'(-v) : W'(v);
  endfunction

  // product operand select, in order x0 x1 p00 p01 p10 p11
  kf_pkg::st_t opa, opb;
  always_comb begin
    case (mi_q)
      3'd0:    begin opa = k0_q; opb = y_q;  end
      3'd1:    begin opa = k1_q; opb = y_q;  end
      3'd2:    begin opa = k0_q; opb = pp_q; end
      3'd3:    begin opa = k0_q; opb = pv_q; end
      3'd4:    begin opa = k1_q; opb = pp_q; end
      default: begin opa = k1_q; opb = pv_q; end
    endcase
  end

  logic [NiW-1:0] nidx;
  logic [W:0]     rem_sh;
  logic           nbit;
  assign nidx   = NiW'(dcnt_q - DcW'(FRAC_BITS) - 1'b1);
  assign nbit   = (dcnt_q > DcW'(FRAC_BITS)) ? mn_q[nidx] : 1'b0;
  assign rem_sh = {rem_q[W-1:0], nbit};

  logic [W:0]  q_sh;
  logic [W:0]  q_nx;
  logic        dsub;
  assign q_sh = {quo_q[W-1:0], 1'b0};
  assign dsub = (rem_sh >= md_q);
  assign q_nx = dsub ? (q_sh | (W+1)'(1)) : q_sh;

  logic [2*W-1:0] acc_n;
  always_comb begin
    case (pp_idx_q)
      2'd0:    acc_n = acc_q + (2*W)'(mul_p);
      2'd3:    acc_n = acc_q + ((2*W)'(mul_p) << 48);
      default: acc_n = acc_q + ((2*W)'(mul_p) << 24);
    endcase
  end

  kf_pkg::st_t prod;
  assign prod = kf_pkg::sign_sat({1'b0, acc_q[FRAC_BITS +: W]}, mneg_q,
                                 (acc_q >> (W + FRAC_BITS)) != '0);

  kf_pkg::st_t z;
  assign z = kf_pkg::st_t'(s_axis_tdata[SAMPLE_BITS-1:0]) <<< FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      meas_noise_q <= 32'd65536000;
      init_unc_q <= 32'd65536000;
      drive_pos_q <= '0;
      drive_vel_q <= '0;
      pos_q <= '0; vel_q <= '0; pv_q <= '0; vp_q <= '0;
      pp_q <= kf_pkg::st_t'(32'd65536000);
      vv_q <= kf_pkg::st_t'(32'd65536000);
      y_q <= '0; s_q <= '0; k0_q <= '0; k1_q <= '0;
      x0_q <= '0; x1_q <= '0; p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
      dcnt_q <= '0; rem_q <= '0; md_q <= '0; quo_q <= '0; mn_q <= '0;
      dovf_q <= 1'b0; dneg_q <= 1'b0;
      mi_q <= '0; pp_idx_q <= '0; ma_q <= '0; mb_q <= '0; mneg_q <= 1'b0;
      acc_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (kf_pkg::cfg_idx_e'(cfg_idx_i))
          kf_pkg::CFG_MEAS_NOISE: meas_noise_q <= cfg_data_i;
          kf_pkg::CFG_INIT_UNC: begin
            init_unc_q <= cfg_data_i;
            pos_q <= '0; vel_q <= '0; pv_q <= '0; vp_q <= '0;
            pp_q <= kf_pkg::st_t'(cfg_data_i);
            vv_q <= kf_pkg::st_t'(cfg_data_i);
          end
          kf_pkg::CFG_DRIVE_POS: drive_pos_q <= cfg_data_i;
          kf_pkg::CFG_DRIVE_VEL: drive_vel_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          y_q <= kf_pkg::sat48((W+2)'(z) - (W+2)'(pos_q));
          s_q <= kf_pkg::sat48((W+2)'(pp_q) + (W+2)'({1'b0, meas_noise_q}));
          state_q <= S_PREP;
        end
        S_PREP: begin
          k0_q <= '0; k1_q <= '0;
          rem_q <= '0; quo_q <= '0; dovf_q <= 1'b0;
          dcnt_q <= DcW'(DivN);
          md_q <= {1'b0, magn(s_q)};
          mn_q <= magn(pp_q);
          dneg_q <= pp_q[W-1] ^ s_q[W-1];
          if (s_q == '0) begin
            mi_q <= '0; pp_idx_q <= '0; acc_q <= '0;
            state_q <= S_MUL;
          end else state_q <= S_DIV0;
        end
        S_DIV0, S_DIV1: begin
          if (dcnt_q != '0) begin
            rem_q <= dsub ? (rem_sh - md_q) : rem_sh;
            if (q_nx > LimQ) begin
              dovf_q <= 1'b1;
              quo_q <= LimQ;
            end else begin
              quo_q <= q_nx;
            end
            dcnt_q <= dcnt_q - 1'b1;
          end else if (state_q == S_DIV0) begin
            k0_q <= kf_pkg::sign_sat(quo_q, dneg_q, dovf_q);
            rem_q <= '0; quo_q <= '0; dovf_q <= 1'b0;
            dcnt_q <= DcW'(DivN);
            mn_q <= magn(vp_q);
            dneg_q <= vp_q[W-1] ^ s_q[W-1];
            state_q <= S_DIV1;
          end else begin
            k1_q <= kf_pkg::sign_sat(quo_q, dneg_q, dovf_q);
            mi_q <= '0; pp_idx_q <= '0; acc_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          ma_q <= magn(opa);
          mb_q <= magn(opb);
          mneg_q <= opa[W-1] ^ opb[W-1];
          pp_idx_q <= '0;
          acc_q <= '0;
          state_q <= S_MULACC;
        end
        S_MULACC: begin
          if (pp_idx_q != 2'd3) begin
            acc_q <= acc_n;
            pp_idx_q <= pp_idx_q + 1'b1;
          end else begin
            acc_q <= acc_n;
            pp_idx_q <= '0;
            state_q <= S_PRED;
          end
        end
        S_PRED: begin
          // write back one corrected term, then next product or prediction
          case (mi_q)
            3'd0: x0_q <= kf_pkg::sat48((W+2)'(pos_q) + (W+2)'(prod));
            3'd1: x1_q <= kf_pkg::sat48((W+2)'(vel_q) + (W+2)'(prod));
            3'd2: p00_q <= kf_pkg::sat48((W+2)'(pp_q) - (W+2)'(prod));
            3'd3: p01_q <= kf_pkg::sat48((W+2)'(pv_q) - (W+2)'(prod));
            3'd4: p10_q <= kf_pkg::sat48((W+2)'(vp_q) - (W+2)'(prod));
            default: p11_q <= kf_pkg::sat48((W+2)'(vv_q) - (W+2)'(prod));
          endcase
          if (mi_q != 3'd5) begin
            mi_q <= mi_q + 1'b1;
            state_q <= S_MUL;
          end else state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_vld_q) begin
            // sums are exact in 50 bits, saturated once
            pos_q <= kf_pkg::sat48((W+2)'(x0_q) + (W+2)'(x1_q) + (W+2)'(drive_pos_q));
            vel_q <= kf_pkg::sat48((W+2)'(x1_q) + (W+2)'(drive_vel_q));
            pp_q <= kf_pkg::sat48((W+2)'(p00_q) + (W+2)'(p01_q)
                                  + (W+2)'(p10_q) + (W+2)'(p11_q));
            pv_q <= kf_pkg::sat48((W+2)'(p01_q) + (W+2)'(p11_q));
            vp_q <= kf_pkg::sat48((W+2)'(p10_q) + (W+2)'(p11_q));
            vv_q <= p11_q;
            out_vld_q <= 1'b1;
          end else if (m_axis_tready) begin
            out_vld_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {kf_pkg::out32(vel_q), kf_pkg::out32(pos_q)};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepting while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");

endmodule
